// ===== rtl/silhouette_edge_toggle_table_defines.svh =====
// Assertion macros shared by the silhouette edge toggle table RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef SILHOUETTE_EDGE_TOGGLE_TABLE_DEFINES_SVH
`define SILHOUETTE_EDGE_TOGGLE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SETT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SETT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sett_pkg.sv =====
// Types and codes for the silhouette edge toggle table.
// No dependencies; used by sett_slot_ram and the top level.
`timescale 1ns / 1ps

package sett_pkg;

    typedef enum logic [1:0] {
        TAG_EMPTY   = 2'd0,
        TAG_LIVE    = 2'd1,
        TAG_DELETED = 2'd2
    } tag_t;

    // key = high << 16 | low
    typedef struct packed {
        tag_t        tag;
        logic [15:0] high;
        logic [15:0] low;
    } slot_t;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_NEXT  = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_CLEARED   = 3'd3;
    localparam logic [2:0] ST_EDGE      = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;

    localparam int unsigned NUM_W = 11;

endpackage

// ===== rtl/silhouette_edge_toggle_table.sv =====
// Silhouette edge toggle table: one item at a time. After reset the slot memory is wiped,
// and no transfer is taken until the wipe ends. Clear runs the same wipe, then reports.
// Add: home slot from the hash unit, then one probe per cycle through the slot memory's
// read port, once for the reverse-edge lookup and again for the insert. A live reverse
// edge is cancelled and leaves a tombstone; otherwise the edge is inserted, or dropped as
// full. Next: one slot per cycle from the scan position; once the scan is done, the scan
// end is reported without a slot read. Result sits in an output register, so a waiting
// result does not block the next transfer being taken.
// Depends on sett_pkg, sett_slot_ram, sett_hash_mod and the assertion macro header.
`timescale 1ns / 1ps
`include "silhouette_edge_toggle_table_defines.svh"

module silhouette_edge_toggle_table #(
    parameter int unsigned TABLE_SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // action[1:0], start_vertex[17:2], end_vertex[33:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status[2:0], edge_low_vertex[18:3],
                                       // edge_high_vertex[34:19], edge_number[45:35]
);

    localparam int unsigned IW = $clog2(TABLE_SLOTS);
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_HASH_S,
        S_LOOK,
        S_HASH_E,
        S_INS,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t      state_reg;
    state_t      state_next;

    logic [1:0]  in_action;
    logic [15:0] in_start;
    logic [15:0] in_end;

    logic [15:0] s_reg;
    logic [15:0] s_next;
    logic [15:0] e_reg;
    logic [15:0] e_next;
    logic [IW-1:0] ia_reg;
    logic [IW-1:0] ia_next;
    logic [CW-1:0] ic_reg;
    logic [CW-1:0] ic_next;
    logic [CW-1:0] dn_reg;
    logic [CW-1:0] dn_next;
    logic [IW-1:0] da_reg;
    logic [IW-1:0] da_next;
    logic          rv_reg;
    logic          rv_next;
    logic [CW-1:0] scan_pos_reg;
    logic [CW-1:0] scan_pos_next;
    logic [CW-1:0] ret_reg;
    logic [CW-1:0] ret_next;
    logic [IW-1:0] wipe_idx_reg;
    logic [IW-1:0] wipe_idx_next;
    logic          wipe_report_reg;
    logic          wipe_report_next;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [2:0]                  m_status_reg;
    logic [2:0]                  m_status_next;
    logic [15:0]                 m_low_reg;
    logic [15:0]                 m_low_next;
    logic [15:0]                 m_high_reg;
    logic [15:0]                 m_high_next;
    logic [sett_pkg::NUM_W-1:0]  m_num_reg;
    logic [sett_pkg::NUM_W-1:0]  m_num_next;
    logic [2:0]                  p_status_reg;
    logic [2:0]                  p_status_next;
    logic [15:0]                 p_low_reg;
    logic [15:0]                 p_low_next;
    logic [15:0]                 p_high_reg;
    logic [15:0]                 p_high_next;
    logic [sett_pkg::NUM_W-1:0]  p_num_reg;
    logic [sett_pkg::NUM_W-1:0]  p_num_next;

    logic                        fin;
    logic [2:0]                  res_status;
    logic [15:0]                 res_low;
    logic [15:0]                 res_high;
    logic [sett_pkg::NUM_W-1:0]  res_num;
    logic                        probe_stop;
    logic                        out_free;
    logic                        key_match;

    logic            ram_wr_en;
    logic [IW-1:0]   ram_wr_addr;
    sett_pkg::slot_t ram_wr_data;
    logic            ram_rd_en;
    logic [IW-1:0]   ram_rd_addr;
    sett_pkg::slot_t ram_rd_data;

    logic            hash_start;
    logic [15:0]     hash_vertex;
    logic            hash_done;
    logic [IW-1:0]   hash_index;

    sett_slot_ram #(
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sett_hash_mod #(
        .SLOTS (TABLE_SLOTS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .vertex (hash_vertex),
        .done   (hash_done),
        .index  (hash_index)
    );

    assign in_action = s_axis_tdata[1:0];
    assign in_start  = s_axis_tdata[17:2];
    assign in_end    = s_axis_tdata[33:18];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_num_reg, m_high_reg, m_low_reg, m_status_reg};

    assign out_free  = !m_valid_reg || m_axis_tready;
    // reverse edge of (s,e) is stored as s<<16|e
    assign key_match = (ram_rd_data.high == s_reg) && (ram_rd_data.low == e_reg);

    always_comb
    begin
        state_next       = state_reg;
        s_next           = s_reg;
        e_next           = e_reg;
        ia_next          = ia_reg;
        ic_next          = ic_reg;
        dn_next          = dn_reg;
        da_next          = ia_reg;
        scan_pos_next    = scan_pos_reg;
        ret_next         = ret_reg;
        wipe_idx_next    = wipe_idx_reg;
        wipe_report_next = wipe_report_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_status_next    = m_status_reg;
        m_low_next       = m_low_reg;
        m_high_next      = m_high_reg;
        m_num_next       = m_num_reg;
        p_status_next    = p_status_reg;
        p_low_next       = p_low_reg;
        p_high_next      = p_high_reg;
        p_num_next       = p_num_reg;
        fin              = 1'b0;
        res_status       = sett_pkg::ST_INSERTED;
        res_low          = '0;
        res_high         = '0;
        res_num          = '0;
        probe_stop       = 1'b0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = da_reg;
        ram_wr_data      = '0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = ia_reg;
        hash_start       = 1'b0;
        hash_vertex      = (state_reg == S_IDLE) ? in_start : e_reg;

        unique case (state_reg)
            S_WIPE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = wipe_idx_reg;
                wipe_idx_next = wipe_idx_reg + 1'b1;
                if (wipe_idx_reg == IW'(TABLE_SLOTS - 1))
                begin
                    wipe_idx_next = '0;
                    if (wipe_report_reg)
                    begin
                        fin        = 1'b1;
                        res_status = sett_pkg::ST_CLEARED;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    unique case (in_action)
                        sett_pkg::ACT_CLEAR:
                        begin
                            scan_pos_next    = '0;
                            ret_next         = '0;
                            wipe_idx_next    = '0;
                            wipe_report_next = 1'b1;
                            state_next       = S_WIPE;
                        end
                        sett_pkg::ACT_ADD:
                        begin
                            s_next        = in_start;
                            e_next        = in_end;
                            scan_pos_next = '0;
                            ret_next      = '0;
                            hash_start    = 1'b1;
                            state_next    = S_HASH_S;
                        end
                        sett_pkg::ACT_NEXT:
                        begin
                            if (scan_pos_reg == CW'(TABLE_SLOTS))
                            begin
                                fin        = 1'b1;
                                res_status = sett_pkg::ST_DONE;
                                res_num    = sett_pkg::NUM_W'(ret_reg);
                            end
                            else
                            begin
                                ia_next    = scan_pos_reg[IW-1:0];
                                ic_next    = scan_pos_reg;
                                dn_next    = scan_pos_reg;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HASH_S, S_HASH_E:
            begin
                if (hash_done)
                begin
                    ia_next    = hash_index;
                    ic_next    = '0;
                    dn_next    = '0;
                    state_next = (state_reg == S_HASH_S) ? S_LOOK : S_INS;
                end
            end
            S_LOOK:
            begin
                if (rv_reg)
                begin
                    dn_next = dn_reg + 1'b1;
                    if (ram_rd_data.tag == sett_pkg::TAG_LIVE && key_match)
                    begin
                        probe_stop       = 1'b1;
                        ram_wr_en        = 1'b1;
                        ram_wr_data.tag  = sett_pkg::TAG_DELETED;
                        fin              = 1'b1;
                        res_status       = sett_pkg::ST_CANCELLED;
                    end
                    else if (ram_rd_data.tag == sett_pkg::TAG_EMPTY ||
                             dn_reg == CW'(TABLE_SLOTS - 1))
                    begin
                        probe_stop = 1'b1;
                        hash_start = 1'b1;
                        state_next = S_HASH_E;
                    end
                end
            end
            S_INS:
            begin
                if (rv_reg)
                begin
                    dn_next = dn_reg + 1'b1;
                    if (ram_rd_data.tag != sett_pkg::TAG_LIVE)
                    begin
                        probe_stop       = 1'b1;
                        ram_wr_en        = 1'b1;
                        ram_wr_data.tag  = sett_pkg::TAG_LIVE;
                        ram_wr_data.high = e_reg;
                        ram_wr_data.low  = s_reg;
                        fin              = 1'b1;
                        res_status       = sett_pkg::ST_INSERTED;
                    end
                    else if (dn_reg == CW'(TABLE_SLOTS - 1))
                    begin
                        probe_stop = 1'b1;
                        fin        = 1'b1;
                        res_status = sett_pkg::ST_FULL;
                    end
                end
            end
            S_SCAN:
            begin
                if (rv_reg)
                begin
                    dn_next = dn_reg + 1'b1;
                    if (ram_rd_data.tag == sett_pkg::TAG_LIVE)
                    begin
                        probe_stop    = 1'b1;
                        scan_pos_next = dn_reg + 1'b1;
                        ret_next      = ret_reg + 1'b1;
                        fin           = 1'b1;
                        res_status    = sett_pkg::ST_EDGE;
                        res_low       = ram_rd_data.low;
                        res_high      = ram_rd_data.high;
                        res_num       = sett_pkg::NUM_W'(ret_reg);
                    end
                    else if (dn_reg == CW'(TABLE_SLOTS - 1))
                    begin
                        probe_stop    = 1'b1;
                        scan_pos_next = CW'(TABLE_SLOTS);
                        fin           = 1'b1;
                        res_status    = sett_pkg::ST_DONE;
                        res_num       = sett_pkg::NUM_W'(ret_reg);
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = p_status_reg;
                    m_low_next    = p_low_reg;
                    m_high_next   = p_high_reg;
                    m_num_next    = p_num_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // streaming probe reads, one slot per cycle; writes only happen once probing stops
        if ((state_reg == S_LOOK || state_reg == S_INS || state_reg == S_SCAN) &&
            !probe_stop && ic_reg < CW'(TABLE_SLOTS))
        begin
            ram_rd_en = 1'b1;
            ia_next   = (ia_reg == IW'(TABLE_SLOTS - 1)) ? '0 : ia_reg + 1'b1;
            ic_next   = ic_reg + 1'b1;
        end
        rv_next = ram_rd_en;

        if (fin)
        begin
            if (out_free)
            begin
                m_valid_next  = 1'b1;
                m_status_next = res_status;
                m_low_next    = res_low;
                m_high_next   = res_high;
                m_num_next    = res_num;
                state_next    = S_IDLE;
            end
            else
            begin
                p_status_next = res_status;
                p_low_next    = res_low;
                p_high_next   = res_high;
                p_num_next    = res_num;
                state_next    = S_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_WIPE;
            ia_reg          <= '0;
            ic_reg          <= '0;
            dn_reg          <= '0;
            da_reg          <= '0;
            rv_reg          <= 1'b0;
            scan_pos_reg    <= '0;
            ret_reg         <= '0;
            wipe_idx_reg    <= '0;
            wipe_report_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ia_reg          <= ia_next;
            ic_reg          <= ic_next;
            dn_reg          <= dn_next;
            da_reg          <= da_next;
            rv_reg          <= rv_next;
            scan_pos_reg    <= scan_pos_next;
            ret_reg         <= ret_next;
            wipe_idx_reg    <= wipe_idx_next;
            wipe_report_reg <= wipe_report_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        e_reg        <= e_next;
        m_status_reg <= m_status_next;
        m_low_reg    <= m_low_next;
        m_high_reg   <= m_high_next;
        m_num_reg    <= m_num_next;
        p_status_reg <= p_status_next;
        p_low_reg    <= p_low_next;
        p_high_reg   <= p_high_next;
        p_num_reg    <= p_num_next;
    end

    `SETT_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, ram_wr_en, !ram_rd_en,
        "slot write and probe read in the same cycle")
    `SETT_ASSERT_IMP(a_rv_in_probe, clk, rst_n, rv_reg,
        (state_reg == S_LOOK || state_reg == S_INS || state_reg == S_SCAN),
        "read data pending outside a probing state")
    `SETT_ASSERT_IMP(a_ret_le_pos, clk, rst_n, 1'b1, ret_reg <= scan_pos_reg,
        "more edges returned than slots scanned")
    `SETT_ASSERT_NXT(a_add_resets_scan, clk, rst_n,
        (s_axis_tvalid && s_axis_tready && in_action == sett_pkg::ACT_ADD),
        (scan_pos_reg == '0 && ret_reg == '0),
        "add transfer did not restart the scan")

endmodule

// ===== rtl/sett_slot_ram.sv =====
// Slot memory: one write port, one read port, registered read data.
// Depends on sett_pkg for the slot word.
`timescale 1ns / 1ps

module sett_slot_ram #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  sett_pkg::slot_t          wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output sett_pkg::slot_t          rd_data
);

    sett_pkg::slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/sett_hash_mod.sv =====
// Home slot unit: (vertex * 4) mod SLOTS, result registered and flagged by done.
// Mask for a power-of-two table, else reciprocal multiply and back-subtract.
`timescale 1ns / 1ps

module sett_hash_mod #(
    parameter int unsigned SLOTS = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [15:0]              vertex,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] index
);

    localparam int unsigned IW   = $clog2(SLOTS);
    localparam bit          POW2 = (SLOTS == (1 << IW));

    logic [17:0] hv;

    assign hv = {vertex, 2'b00};

    if (POW2)
    begin : g_mask
        logic          done_reg;
        logic [IW-1:0] idx_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= start;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                idx_reg <= hv[IW-1:0];
            end
        end

        assign done  = done_reg;
        assign index = idx_reg;
    end
    else
    begin : g_recip
        // hv < 2^18: a reciprocal scaled by 2^(18+IW) gives the exact quotient
        localparam int unsigned     KSH   = 18 + IW;
        localparam longint unsigned RECIP =
            ((64'd1 << KSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

        logic          p1_reg;
        logic          done_reg;
        logic [17:0]   hv_reg;
        logic [36:0]   prod_reg;
        logic [36:0]   quo;
        logic [36:0]   back;
        logic [17:0]   rem;
        logic [IW-1:0] idx_reg;

        assign quo  = prod_reg >> KSH;
        assign back = quo * 37'(SLOTS);
        assign rem  = hv_reg - back[17:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p1_reg   <= 1'b0;
                done_reg <= 1'b0;
            end
            else
            begin
                p1_reg   <= start;
                done_reg <= p1_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                hv_reg   <= hv;
                prod_reg <= 37'(hv) * 37'(RECIP);
            end
            if (p1_reg)
            begin
                idx_reg <= rem[IW-1:0];
            end
        end

        assign done  = done_reg;
        assign index = idx_reg;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for silhouette_edge_toggle_table: stream driver, result monitor
// and a cycle-free predictor of the edge hash table. Depends on sett_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;

    import sett_pkg::*;

    localparam int unsigned SLOTS = 1024;
    localparam int unsigned RANDOM_CMDS = 530;
    localparam int unsigned FILL_ADDS = 64;
    localparam int unsigned DRAIN_CYCLES = 2200;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] start_v;
        logic [15:0] end_v;
    } edge_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] low_v;
        logic [15:0] high_v;
        logic [10:0] number;
    } edge_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // action, start_vertex, end_vertex
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // status, edge_low_vertex, edge_high_vertex, edge_number

    edge_cmd_t    pending_cmds[$];
    edge_result_t expected_results[$];

    // predictor copy of the table
    logic [31:0] slot_key[SLOTS];
    tag_t        slot_tag[SLOTS];
    int unsigned scan_pos;
    int unsigned edges_given;

    int unsigned cmds_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned action_hits[4] = '{default: 0};
    int unsigned status_hits[8] = '{default: 0};
    bit          in_taken = 1'b0;
    bit          hold_off = 1'b0;

    silhouette_edge_toggle_table #(
        .TABLE_SLOTS(SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit roll(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // idling pattern cycles through four phases as transfers go by
    function automatic int unsigned idle_phase();
        return (cmds_taken / 128) % 4;
    endfunction

    function automatic void wipe_table();
        for (int unsigned k = 0; k < SLOTS; k++)
        begin
            slot_key[k] = '0;
            slot_tag[k] = TAG_EMPTY;
        end
        scan_pos = 0;
        edges_given = 0;
    endfunction

    task automatic push_cmd(input logic [1:0] action, input logic [15:0] sv,
                            input logic [15:0] ev);
        edge_cmd_t c;
        begin
            c.action = action;
            c.start_v = sv;
            c.end_v = ev;
            pending_cmds.push_back(c);
        end
    endtask

    task automatic toggle_table_step(input edge_cmd_t c, output bit produced,
                                     output edge_result_t r);
        logic [31:0] reverse_key;
        logic [31:0] new_key;
        int unsigned idx;
        int unsigned n;
        bit          settled;
        begin
            produced = 1'b1;
            r = '0;
            settled = 1'b0;
            reverse_key = {c.start_v, c.end_v};
            new_key = {c.end_v, c.start_v};
            case (c.action)
                ACT_CLEAR:
                begin
                    wipe_table();
                    r.status = ST_CLEARED;
                end
                ACT_ADD:
                begin
                    scan_pos = 0;
                    edges_given = 0;
                    idx = (int'(c.start_v) * 4) % SLOTS;
                    for (n = 0; n < SLOTS && slot_tag[idx] != TAG_EMPTY && !settled; n++)
                    begin
                        if (slot_tag[idx] == TAG_LIVE && slot_key[idx] == reverse_key)
                        begin
                            slot_tag[idx] = TAG_DELETED;
                            slot_key[idx] = '0;
                            r.status = ST_CANCELLED;
                            settled = 1'b1;
                        end
                        else
                        begin
                            idx = (idx + 1) % SLOTS;
                        end
                    end
                    idx = (int'(c.end_v) * 4) % SLOTS;
                    for (n = 0; n < SLOTS && !settled; n++)
                    begin
                        if (slot_tag[idx] != TAG_LIVE)
                        begin
                            slot_tag[idx] = TAG_LIVE;
                            slot_key[idx] = new_key;
                            r.status = ST_INSERTED;
                            settled = 1'b1;
                        end
                        else
                        begin
                            idx = (idx + 1) % SLOTS;
                        end
                    end
                    if (!settled)
                        r.status = ST_FULL;
                end
                ACT_NEXT:
                begin
                    while (scan_pos < SLOTS && !settled)
                    begin
                        idx = scan_pos;
                        scan_pos++;
                        if (slot_tag[idx] == TAG_LIVE)
                        begin
                            r.status = ST_EDGE;
                            r.low_v = slot_key[idx][15:0];
                            r.high_v = slot_key[idx][31:16];
                            r.number = edges_given[10:0];
                            edges_given++;
                            settled = 1'b1;
                        end
                    end
                    if (!settled)
                    begin
                        r.status = ST_DONE;
                        r.number = edges_given[10:0];
                    end
                end
                default:
                    produced = 1'b0;
            endcase
        end
    endtask

    // stimulus, reset and end of run
    initial
    begin : stimulus
        logic [15:0] pool[6];
        logic [15:0] base;
        logic [15:0] fill_s;
        logic [15:0] kept_s;
        logic [7:0]  kept_k;
        int unsigned random_cmds;
        int unsigned pick;
        int unsigned nadd;
        int unsigned nnext;

        wipe_table();

        // directed: empty scan, all-zero and all-ones keys, home-slot collision,
        // scan end, cancel leaving a tombstone, probe past it, reuse it, unused action
        push_cmd(ACT_NEXT, 16'h0000, 16'h0000);
        push_cmd(ACT_ADD, 16'h0000, 16'h0000);
        push_cmd(ACT_ADD, 16'h0000, 16'h0000);
        push_cmd(ACT_ADD, 16'hFFFF, 16'hFFFF);
        push_cmd(ACT_ADD, 16'h0000, 16'hFFFF);
        push_cmd(ACT_ADD, 16'hFFFF, 16'h0000);
        push_cmd(ACT_ADD, 16'd1, 16'd2);
        push_cmd(ACT_ADD, 16'd257, 16'd2);
        repeat (5) push_cmd(ACT_NEXT, 16'hFFFF, 16'hFFFF);
        push_cmd(ACT_ADD, 16'd2, 16'd1);
        push_cmd(ACT_ADD, 16'd2, 16'd257);
        push_cmd(ACT_ADD, 16'd513, 16'd2);
        push_cmd(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
        repeat (2) push_cmd(ACT_NEXT, 16'h0000, 16'h0000);
        push_cmd(ACT_CLEAR, 16'hFFFF, 16'h0000);
        push_cmd(ACT_NEXT, 16'h0000, 16'h0000);

        // long collision run from a home slot near the top, wrapping round to slot 0;
        // lookups start at slot 1020 and walk the run once it reaches there;
        // then cancel one edge deep inside the run and reuse its tombstone
        push_cmd(ACT_CLEAR, 16'h0000, 16'h0000);
        kept_k = 8'($urandom_range(20, 60));
        kept_s = 16'hFFFF;
        for (int unsigned k = 0; k < FILL_ADDS; k++)
        begin
            fill_s = 16'(255 + 256 * $urandom_range(1, 255));
            if (k == kept_k)
                kept_s = fill_s;
            push_cmd(ACT_ADD, fill_s, 16'd254);
        end
        push_cmd(ACT_ADD, 16'($urandom_range(256, 65535)), 16'($urandom_range(0, 65535)));
        push_cmd(ACT_ADD, 16'd254, kept_s);
        push_cmd(ACT_ADD, 16'($urandom_range(256, 65535)), 16'd254);
        repeat (4) push_cmd(ACT_NEXT, 16'($urandom), 16'($urandom));
        push_cmd(ACT_CLEAR, 16'($urandom), 16'($urandom));

        // random mesh-like episodes over small vertex pools
        random_cmds = 0;
        while (random_cmds < RANDOM_CMDS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                push_cmd(ACT_CLEAR, 16'($urandom), 16'($urandom));
                random_cmds++;
            end
            base = 16'($urandom_range(0, 65535));
            foreach (pool[v])
            begin
                case ($urandom_range(0, 2))
                    0: pool[v] = 16'($urandom_range(0, 65535));
                    1: pool[v] = base ^ {8'($urandom_range(0, 255)), 8'h00};
                    default: pool[v] = 16'($urandom_range(0, 3));
                endcase
            end
            nadd = $urandom_range(4, 30);
            for (int unsigned a = 0; a < nadd; a++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                begin
                    push_cmd(ACT_UNUSED, 16'($urandom), 16'($urandom));
                end
                else
                begin
                    if (pick == 1)
                        push_cmd(ACT_ADD, 16'($urandom), 16'($urandom));
                    else if (pick == 2)
                        push_cmd(ACT_NEXT, 16'($urandom), 16'($urandom));
                    else
                        push_cmd(ACT_ADD, pool[$urandom_range(0, 5)],
                                 pool[$urandom_range(0, 5)]);
                    random_cmds++;
                end
            end
            nnext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(10, 45);
            repeat (nnext) push_cmd(ACT_NEXT, 16'($urandom), 16'($urandom));
            random_cmds += nnext;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transfers: %0d clears, %0d adds, %0d nexts, %0d unused;",
                 cmds_taken, action_hits[ACT_CLEAR], action_hits[ACT_ADD],
                 action_hits[ACT_NEXT], action_hits[ACT_UNUSED]);
        $display("results %0d: %0d inserted, %0d cancelled, %0d full, %0d edges, %0d scan ends",
                 results_seen, status_hits[ST_INSERTED], status_hits[ST_CANCELLED],
                 status_hits[ST_FULL], status_hits[ST_EDGE], status_hits[ST_DONE]);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout: %0d transfers taken, %0d results outstanding",
                 cmds_taken, expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    // long receiver hold-off so the output register fills and input stalls
    initial
    begin
        wait (cmds_taken >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // driver
    always @(negedge clk)
    begin : drive_cmds
        edge_cmd_t c;
        int unsigned idle_pct;
        idle_pct = (idle_phase() == 1) ? 66 : (idle_phase() == 3) ? 26 : 0;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (s_axis_tvalid && !in_taken)
        begin
            // hold until the transfer completes
        end
        else if (pending_cmds.size() != 0 && !roll(idle_pct))
        begin
            c = pending_cmds.pop_front();
            s_axis_tdata <= {6'd0, c.end_v, c.start_v, c.action};
            s_axis_tvalid <= 1'b1;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : drive_ready
        int unsigned stall_pct;
        stall_pct = (idle_phase() == 2) ? 66 : (idle_phase() == 3) ? 26 : 0;
        m_axis_tready <= !hold_off && !roll(stall_pct);
    end

    // predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin : predict_and_check
        edge_cmd_t    c;
        edge_result_t want;
        edge_result_t got;
        bit           produced;
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            c.action = s_axis_tdata[1:0];
            c.start_v = s_axis_tdata[17:2];
            c.end_v = s_axis_tdata[33:18];
            toggle_table_step(c, produced, want);
            if (produced)
                expected_results.push_back(want);
            action_hits[c.action]++;
            cmds_taken <= cmds_taken + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tdata[2:0];
            got.low_v = m_axis_tdata[18:3];
            got.high_v = m_axis_tdata[34:19];
            got.number = m_axis_tdata[45:35];
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t: unexpected result status=%0d low=%h high=%h num=%0d",
                             $realtime, got.status, got.low_v, got.high_v, got.number);
            end
            else
            begin
                want = expected_results.pop_front();
                status_hits[want.status]++;
                if (got.status !== want.status || got.low_v !== want.low_v ||
                    got.high_v !== want.high_v || got.number !== want.number)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%t: result %0d exp st=%0d lo=%h hi=%h n=%0d",
                                  " got st=%0d lo=%h hi=%h n=%0d"},
                                 $realtime, results_seen, want.status, want.low_v,
                                 want.high_v, want.number, got.status, got.low_v,
                                 got.high_v, got.number);
                end
            end
        end
    end

endmodule
